FILE: hw/rtl/sonar_wall_follow_steering_unit_assert.svh
// Assertion macros used by the steering unit controller RTL.
// Needs i_clk and i_rst_n in the scope that uses them.
`ifndef SONAR_WALL_FOLLOW_STEERING_UNIT_ASSERT_SVH
`define SONAR_WALL_FOLLOW_STEERING_UNIT_ASSERT_SVH

// antecedent in this cycle implies consequent in the same cycle
`define SWF_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("steering unit assertion failed");

// antecedent in this cycle implies consequent in the next cycle
`define SWF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("steering unit assertion failed");

`endif

FILE: hw/rtl/swf_pkg.sv
// Shared types, constants and tables of the sonar wall-follow steering unit.
// No dependencies.
`default_nettype none

package swf_pkg;

    localparam int RANGE_FRAC_BITS_DEF = 12;
    localparam int CORDIC_STEPS        = 20;
    localparam int SQRT_STEPS          = 21;
    localparam int STEP_W              = 5;
    localparam int HALF_PI_Q12         = 6434;
    localparam int INV_GAIN_Q20        = 636751;
    localparam int ANG_MAX             = 524287;
    localparam int ANG_MIN             = -524288;
    localparam int CFG_IDX_W           = 4;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN_DIST      = 4'd0,
        CFG_GAIN_ORIENT    = 4'd1,
        CFG_FRONT_COS_A    = 4'd2,
        CFG_FRONT_COS_B    = 4'd3,
        CFG_FAR_THRESHOLD  = 4'd4,
        CFG_NEAR_THRESHOLD = 4'd5,
        CFG_FAST_SPEED     = 4'd6,
        CFG_SLOW_SPEED     = 4'd7
    } t_cfg_idx;

    localparam logic [15:0] RST_GAIN_DIST      = 16'd256;
    localparam logic [15:0] RST_GAIN_ORIENT    = 16'd256;
    localparam logic [15:0] RST_FRONT_COS_A    = 16'd16384;
    localparam logic [15:0] RST_FRONT_COS_B    = 16'd16384;
    localparam logic [15:0] RST_FAR_THRESHOLD  = 16'd12288;
    localparam logic [15:0] RST_NEAR_THRESHOLD = 16'd4096;
    localparam logic [15:0] RST_FAST_SPEED     = 16'd3277;
    localparam logic [15:0] RST_SLOW_SPEED     = 16'd1638;

    typedef struct packed {
        logic signed [15:0] gain_dist;
        logic signed [15:0] gain_orient;
        logic signed [15:0] front_cos_a;
        logic signed [15:0] front_cos_b;
        logic [15:0]        far_threshold;
        logic [15:0]        near_threshold;
        logic [15:0]        fast_speed;
        logic [15:0]        slow_speed;
    } t_cfg;

    // datapath operations
    typedef enum logic [4:0] {
        OP_NONE,
        OP_CAPTURE,
        OP_FRONT_A,
        OP_FRONT_B,
        OP_SQ_X,
        OP_SQ_Y,
        OP_SQRT,
        OP_ATAN_INIT,
        OP_ATAN_STEP,
        OP_ATAN_FIN,
        OP_COS_INIT,
        OP_COS_STEP,
        OP_COS_FIN,
        OP_LAT,
        OP_ANG_A,
        OP_ANG_B,
        OP_LOAD_OUT
    } t_op;

    typedef struct packed {
        t_op  op;
        logic out_zero;
    } t_cmd;

    typedef struct packed {
        logic sqrt_last;
        logic cordic_last;
    } t_sts;

    // arctan(2^-i) in Q.20
    function automatic logic [19:0] atan_q20(input logic [STEP_W-1:0] idx);
        logic [19:0] v;
        unique case (idx)
            5'd0:    v = 20'd823550;
            5'd1:    v = 20'd486170;
            5'd2:    v = 20'd256879;
            5'd3:    v = 20'd130396;
            5'd4:    v = 20'd65451;
            5'd5:    v = 20'd32757;
            5'd6:    v = 20'd16383;
            5'd7:    v = 20'd8192;
            5'd8:    v = 20'd4096;
            5'd9:    v = 20'd2048;
            5'd10:   v = 20'd1024;
            5'd11:   v = 20'd512;
            5'd12:   v = 20'd256;
            5'd13:   v = 20'd128;
            5'd14:   v = 20'd64;
            5'd15:   v = 20'd32;
            5'd16:   v = 20'd16;
            5'd17:   v = 20'd8;
            5'd18:   v = 20'd4;
            5'd19:   v = 20'd2;
            default: v = 20'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/swf_datapath.sv
// Datapath of the steering unit: shared multiplier, square root, CORDIC, output regs.
// Depends on swf_pkg; driven by swf_controller commands.
`default_nettype none

module swf_datapath
    import swf_pkg::*;
#(
    parameter int RANGE_FRAC_BITS = RANGE_FRAC_BITS_DEF
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  t_cmd               i_cmd,
    input  t_cfg               i_cfg,
    input  wire signed [19:0]  i_pos_x,
    input  wire signed [19:0]  i_pos_y,
    input  wire [15:0]         i_left_range,
    input  wire [15:0]         i_right_range,
    input  wire [15:0]         i_front_range_a,
    input  wire [15:0]         i_front_range_b,
    output t_sts               o_sts,
    output logic [15:0]        o_linear_speed,
    output logic signed [19:0] o_angular_speed,
    output logic               o_follow_right
);

    localparam int RFB = RANGE_FRAC_BITS;
    localparam int CW  = 24 + RFB;
    localparam int ZW  = 24;
    localparam int AW  = 40 + RFB;
    localparam logic signed [17:0] OFFSET = 18'(((105 << RFB) + 500) / 1000);
    localparam logic signed [AW-1:0] V_HI = AW'(ANG_MAX);
    localparam logic signed [AW-1:0] V_LO = AW'(ANG_MIN);
    localparam logic signed [AW-1:0] V_RND = AW'(1) <<< (7 + RFB);

    // item and history registers
    logic signed [19:0] r_prev_x, r_prev_y;
    logic [15:0]        r_prev_left, r_prev_right;
    logic [15:0]        r_fa, r_fb, r_dp;
    logic signed [20:0] r_dx, r_dy;
    logic signed [16:0] r_dr;
    logic signed [17:0] r_side;
    logic               r_right;

    // intermediate results
    logic [17:0]          r_sum;
    logic [15:0]          r_speed;
    logic [41:0]          r_sq, r_rad;
    logic [22:0]          r_rem;
    logic [20:0]          r_root;
    logic signed [CW-1:0] r_cx, r_cy;
    logic signed [ZW-1:0] r_cz;
    logic                 r_yz, r_xz;
    logic signed [14:0]   r_oe;
    logic [14:0]          r_c;
    logic signed [19:0]   r_de;
    logic signed [AW-1:0] r_acc;
    logic [STEP_W-1:0]    r_step;

    logic signed [21:0] mul_a, mul_b;
    logic signed [43:0] prod, prod_abs, prod_sh;
    logic [16:0]        front_part;
    logic [16:0]        med;
    logic [23:0]        rem_sh, trial;
    logic signed [CW-1:0] xs, ys, cos_t;
    logic signed [ZW-1:0] ang_step, atan_t;
    logic                 up;
    logic signed [AW-1:0] v_sh;
    logic signed [19:0]   v_sat;

    // select multiplier operands
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (i_cmd.op)
            OP_FRONT_A: begin
                mul_a = 22'(i_cfg.front_cos_a);
                mul_b = 22'(r_fa);
            end
            OP_FRONT_B: begin
                mul_a = 22'(i_cfg.front_cos_b);
                mul_b = 22'(r_fb);
            end
            OP_SQ_X: begin
                mul_a = 22'(r_dx);
                mul_b = 22'(r_dx);
            end
            OP_SQ_Y: begin
                mul_a = 22'(r_dy);
                mul_b = 22'(r_dy);
            end
            OP_LAT: begin
                mul_a = 22'(r_side);
                mul_b = 22'(r_c);
            end
            OP_ANG_A: begin
                mul_a = 22'(i_cfg.gain_dist);
                mul_b = 22'(r_de);
            end
            OP_ANG_B: begin
                mul_a = 22'(i_cfg.gain_orient);
                mul_b = 22'(r_oe);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod       = mul_a * mul_b;
    assign prod_abs   = prod[43] ? -prod : prod;
    assign front_part = prod_abs[30:14];
    assign prod_sh    = prod >>> 14;
    assign med        = r_sum[17:1];

    // one square root digit
    assign rem_sh = {r_rem[21:0], r_rad[41:40]};
    assign trial  = {1'b0, r_root, 2'b01};

    // one CORDIC micro-rotation
    assign xs       = r_cx >>> r_step;
    assign ys       = r_cy >>> r_step;
    assign ang_step = ZW'(atan_q20(r_step));
    assign up       = (i_cmd.op == OP_ATAN_STEP) ? (r_cy > 0) : r_cz[ZW-1];
    assign atan_t   = (r_cz + ZW'(128)) >>> 8;
    assign cos_t    = (r_cx + CW'(32)) >>> 6;

    // round, scale and saturate the steering sum
    assign v_sh = (r_acc + V_RND) >>> (8 + RFB);
    always_comb begin
        if (v_sh > V_HI) begin
            v_sat = 20'(ANG_MAX);
        end else if (v_sh < V_LO) begin
            v_sat = 20'(ANG_MIN);
        end else begin
            v_sat = v_sh[19:0];
        end
    end

    // step counter for the iterative units
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
        end else if (i_cmd.op == OP_SQRT || i_cmd.op == OP_ATAN_STEP ||
                     i_cmd.op == OP_COS_STEP) begin
            r_step <= r_step + 1'b1;
        end else begin
            r_step <= '0;
        end
    end

    assign o_sts.sqrt_last   = (r_step == STEP_W'(SQRT_STEPS - 1));
    assign o_sts.cordic_last = (r_step == STEP_W'(CORDIC_STEPS - 1));

    // execute the commanded operation
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            OP_CAPTURE: begin
                r_dx         <= 21'(i_pos_x) - 21'(r_prev_x);
                r_dy         <= 21'(i_pos_y) - 21'(r_prev_y);
                r_right      <= (i_left_range >= i_right_range);
                r_dp         <= 16'((17'(i_left_range) + 17'(i_right_range)) >> 1);
                r_fa         <= i_front_range_a;
                r_fb         <= i_front_range_b;
                if (i_left_range >= i_right_range) begin
                    r_dr   <= $signed(17'(r_prev_right)) - $signed(17'(i_right_range));
                    r_side <= OFFSET - $signed(18'(i_right_range));
                end else begin
                    r_dr   <= $signed(17'(i_left_range)) - $signed(17'(r_prev_left));
                    r_side <= $signed(18'(i_left_range)) + OFFSET;
                end
                r_prev_x     <= i_pos_x;
                r_prev_y     <= i_pos_y;
                r_prev_left  <= i_left_range;
                r_prev_right <= i_right_range;
            end
            OP_FRONT_A: begin
                r_sum <= 18'(front_part);
            end
            OP_FRONT_B: begin
                r_sum <= r_sum + 18'(front_part);
            end
            OP_SQ_X: begin
                r_sq <= prod[41:0];
                if (med >= 17'(i_cfg.far_threshold)) begin
                    r_speed <= i_cfg.fast_speed;
                end else if (med > 17'(i_cfg.near_threshold)) begin
                    r_speed <= i_cfg.slow_speed;
                end else begin
                    r_speed <= '0;
                end
            end
            OP_SQ_Y: begin
                r_rad  <= r_sq + prod[41:0];
                r_rem  <= '0;
                r_root <= '0;
            end
            OP_SQRT: begin
                r_rad <= {r_rad[39:0], 2'b00};
                if (rem_sh >= trial) begin
                    r_rem  <= 23'(rem_sh - trial);
                    r_root <= {r_root[19:0], 1'b1};
                end else begin
                    r_rem  <= 23'(rem_sh);
                    r_root <= {r_root[19:0], 1'b0};
                end
            end
            OP_ATAN_INIT: begin
                r_cx <= $signed(CW'(r_root) << RFB);
                r_cy <= CW'(r_dr) <<< 12;
                r_cz <= '0;
                r_yz <= (r_dr == '0);
                r_xz <= (r_root == '0);
            end
            OP_ATAN_STEP, OP_COS_STEP: begin
                if (up) begin
                    r_cx <= r_cx + ys;
                    r_cy <= r_cy - xs;
                    r_cz <= r_cz + ang_step;
                end else begin
                    r_cx <= r_cx - ys;
                    r_cy <= r_cy + xs;
                    r_cz <= r_cz - ang_step;
                end
            end
            OP_ATAN_FIN: begin
                if (r_yz) begin
                    r_oe <= '0;
                end else if (r_xz) begin
                    r_oe <= r_dr[16] ? -15'(HALF_PI_Q12) : 15'(HALF_PI_Q12);
                end else begin
                    r_oe <= atan_t[14:0];
                end
            end
            OP_COS_INIT: begin
                r_cx <= CW'(INV_GAIN_Q20);
                r_cy <= '0;
                r_cz <= ZW'(r_oe) <<< 8;
            end
            OP_COS_FIN: begin
                if (cos_t < 0) begin
                    r_c <= '0;
                end else if (cos_t > CW'(16384)) begin
                    r_c <= 15'd16384;
                end else begin
                    r_c <= cos_t[14:0];
                end
            end
            OP_LAT: begin
                if (r_right) begin
                    r_de <= 20'(prod_sh + 44'(r_dp));
                end else begin
                    r_de <= 20'(prod_sh - 44'(r_dp));
                end
            end
            OP_ANG_A: begin
                r_acc <= AW'(prod) <<< 12;
            end
            OP_ANG_B: begin
                r_acc <= r_acc + (AW'(prod) <<< RFB);
            end
            OP_LOAD_OUT: begin
                if (i_cmd.out_zero) begin
                    o_linear_speed  <= '0;
                    o_angular_speed <= '0;
                    o_follow_right  <= 1'b0;
                end else begin
                    o_linear_speed  <= r_speed;
                    o_angular_speed <= (r_speed == '0) ? '0 : v_sat;
                    o_follow_right  <= r_right;
                end
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: hw/rtl/swf_controller.sv
// Sequencer of the steering unit: handshakes, priming and datapath commands.
// Depends on swf_pkg and the assertion macro header.
`default_nettype none

`include "sonar_wall_follow_steering_unit_assert.svh"

module swf_controller
    import swf_pkg::*;
(
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  wire   i_s_tvalid,
    output logic  o_s_tready,
    output logic  o_m_tvalid,
    input  wire   i_m_tready,
    input  t_sts  i_sts,
    output t_cmd  o_cmd
);

    typedef enum logic [15:0] {
        S_IDLE      = 16'h0001,
        S_FRONT_A   = 16'h0002,
        S_FRONT_B   = 16'h0004,
        S_SQ_X      = 16'h0008,
        S_SQ_Y      = 16'h0010,
        S_SQRT      = 16'h0020,
        S_ATAN_INIT = 16'h0040,
        S_ATAN      = 16'h0080,
        S_ATAN_FIN  = 16'h0100,
        S_COS_INIT  = 16'h0200,
        S_COS       = 16'h0400,
        S_COS_FIN   = 16'h0800,
        S_LAT       = 16'h1000,
        S_ANG_A     = 16'h2000,
        S_ANG_B     = 16'h4000,
        S_DONE      = 16'h8000
    } t_state;

    t_state r_state, n_state;
    logic   r_primed, n_primed;
    logic   r_zero, n_zero;
    logic   r_o_valid, n_o_valid;

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_o_valid;

    // next state and command
    always_comb begin
        n_state      = r_state;
        n_primed     = r_primed;
        n_zero       = r_zero;
        n_o_valid    = r_o_valid & ~i_m_tready;
        o_cmd.op       = OP_NONE;
        o_cmd.out_zero = r_zero;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.op = OP_CAPTURE;
                    n_primed = 1'b1;
                    n_zero   = ~r_primed;
                    n_state  = r_primed ? S_FRONT_A : S_DONE;
                end
            end
            S_FRONT_A: begin
                o_cmd.op = OP_FRONT_A;
                n_state  = S_FRONT_B;
            end
            S_FRONT_B: begin
                o_cmd.op = OP_FRONT_B;
                n_state  = S_SQ_X;
            end
            S_SQ_X: begin
                o_cmd.op = OP_SQ_X;
                n_state  = S_SQ_Y;
            end
            S_SQ_Y: begin
                o_cmd.op = OP_SQ_Y;
                n_state  = S_SQRT;
            end
            S_SQRT: begin
                o_cmd.op = OP_SQRT;
                if (i_sts.sqrt_last) begin
                    n_state = S_ATAN_INIT;
                end
            end
            S_ATAN_INIT: begin
                o_cmd.op = OP_ATAN_INIT;
                n_state  = S_ATAN;
            end
            S_ATAN: begin
                o_cmd.op = OP_ATAN_STEP;
                if (i_sts.cordic_last) begin
                    n_state = S_ATAN_FIN;
                end
            end
            S_ATAN_FIN: begin
                o_cmd.op = OP_ATAN_FIN;
                n_state  = S_COS_INIT;
            end
            S_COS_INIT: begin
                o_cmd.op = OP_COS_INIT;
                n_state  = S_COS;
            end
            S_COS: begin
                o_cmd.op = OP_COS_STEP;
                if (i_sts.cordic_last) begin
                    n_state = S_COS_FIN;
                end
            end
            S_COS_FIN: begin
                o_cmd.op = OP_COS_FIN;
                n_state  = S_LAT;
            end
            S_LAT: begin
                o_cmd.op = OP_LAT;
                n_state  = S_ANG_A;
            end
            S_ANG_A: begin
                o_cmd.op = OP_ANG_A;
                n_state  = S_ANG_B;
            end
            S_ANG_B: begin
                o_cmd.op = OP_ANG_B;
                n_state  = S_DONE;
            end
            S_DONE: begin
                // hold until the output register is free
                if (!r_o_valid || i_m_tready) begin
                    o_cmd.op  = OP_LOAD_OUT;
                    n_o_valid = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_primed  <= 1'b0;
            r_zero    <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_primed  <= n_primed;
            r_zero    <= n_zero;
            r_o_valid <= n_o_valid;
        end
    end

    `SWF_ASSERT_NEXT(a_busy_after_accept, i_s_tvalid && o_s_tready, r_state != S_IDLE)
    `SWF_ASSERT_NEXT(a_done_waits, r_state == S_DONE && r_o_valid && !i_m_tready, r_state == S_DONE)
    `SWF_ASSERT_NEXT(a_sqrt_runs, r_state == S_SQRT && !i_sts.sqrt_last, r_state == S_SQRT)
    `SWF_ASSERT_SAME(a_primed_work, r_state != S_IDLE && r_state != S_DONE, r_primed)

endmodule

`default_nettype wire

FILE: hw/rtl/sonar_wall_follow_steering_unit.sv
// Channel      Dir  Fields (lowest bit first)
// s_axis       in   tdata: pos_x[19:0] pos_y[39:20] left[55:40] right[71:56] front_a, front_b
// m_axis       out  tdata: linear_speed[15:0] angular_speed[35:16]; tuser: follow_right
// cfg          in   index[3:0], data[15:0]; always ready, indexes above 7 ignored
//
// Each item runs through a 21-step square root and two 20-step CORDIC passes in
// turn; no new item is accepted until its result is loaded. The first item after
// reset only primes the history and gives an all-zero result.
// A finished result waits in the output register; the next item is accepted
// meanwhile. Reset is synchronous, active low; no clearing pass.
`default_nettype none

module sonar_wall_follow_steering_unit
    import swf_pkg::*;
#(
    parameter int RANGE_FRAC_BITS = RANGE_FRAC_BITS_DEF
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  s_axis_tvalid,
    output logic                 s_axis_tready,
    input  wire [103:0]          s_axis_tdata,   // pos_x, pos_y, left, right, front_a, front_b
    output logic                 m_axis_tvalid,
    input  wire                  m_axis_tready,
    output logic [39:0]          m_axis_tdata,   // linear_speed, angular_speed, zero pad
    output logic                 m_axis_tuser,   // follow_right
    input  wire                  i_cfg_valid,
    output logic                 o_cfg_ready,
    input  wire [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire [15:0]           i_cfg_data
);

    t_cfg r_cfg;
    t_cmd cmd;
    t_sts sts;
    logic [15:0]        lin;
    logic signed [19:0] ang;
    logic               fol;

    // register file writes
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain_dist      <= RST_GAIN_DIST;
            r_cfg.gain_orient    <= RST_GAIN_ORIENT;
            r_cfg.front_cos_a    <= RST_FRONT_COS_A;
            r_cfg.front_cos_b    <= RST_FRONT_COS_B;
            r_cfg.far_threshold  <= RST_FAR_THRESHOLD;
            r_cfg.near_threshold <= RST_NEAR_THRESHOLD;
            r_cfg.fast_speed     <= RST_FAST_SPEED;
            r_cfg.slow_speed     <= RST_SLOW_SPEED;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_GAIN_DIST:      r_cfg.gain_dist      <= i_cfg_data;
                CFG_GAIN_ORIENT:    r_cfg.gain_orient    <= i_cfg_data;
                CFG_FRONT_COS_A:    r_cfg.front_cos_a    <= i_cfg_data;
                CFG_FRONT_COS_B:    r_cfg.front_cos_b    <= i_cfg_data;
                CFG_FAR_THRESHOLD:  r_cfg.far_threshold  <= i_cfg_data;
                CFG_NEAR_THRESHOLD: r_cfg.near_threshold <= i_cfg_data;
                CFG_FAST_SPEED:     r_cfg.fast_speed     <= i_cfg_data;
                CFG_SLOW_SPEED:     r_cfg.slow_speed     <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    swf_controller u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .o_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    swf_datapath #(
        .RANGE_FRAC_BITS (RANGE_FRAC_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_cfg           (r_cfg),
        .i_pos_x         (s_axis_tdata[19:0]),
        .i_pos_y         (s_axis_tdata[39:20]),
        .i_left_range    (s_axis_tdata[55:40]),
        .i_right_range   (s_axis_tdata[71:56]),
        .i_front_range_a (s_axis_tdata[87:72]),
        .i_front_range_b (s_axis_tdata[103:88]),
        .o_sts           (sts),
        .o_linear_speed  (lin),
        .o_angular_speed (ang),
        .o_follow_right  (fol)
    );

    assign m_axis_tdata = {4'b0000, ang, lin};
    assign m_axis_tuser = fol;

endmodule

`default_nettype wire
